/* rtl/utf8v_pkg.sv */
// ----------------------------------------------------------------------------
// utf8v_pkg - shared types and tables for the UTF-8 validating decoder
// Byte classes, automaton transitions and the step result struct.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned CNT_OUT_W = 32;
  localparam int unsigned STATUS_W  = 2;

  typedef logic [STATE_W-1:0] dfa_state_t;
  typedef logic [CLASS_W-1:0] byte_class_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam dfa_state_t ST_ACCEPT = 4'd0;
  localparam dfa_state_t ST_REJECT = 4'd1;

  localparam status_t STATUS_ACCEPT  = 2'd0;
  localparam status_t STATUS_INSIDE  = 2'd1;
  localparam status_t STATUS_INVALID = 2'd2;

  // Outcome of one automaton step
  typedef struct packed {
    dfa_state_t      state;
    logic [CP_W-1:0] value;
    logic            cp_done;
    logic            reject;
  } step_t;

  function automatic byte_class_t byte_class(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    case (b) inside
      [8'h00:8'h7F]:        c = 4'd0;
      [8'h80:8'h8F]:        c = 4'd1;
      [8'h90:8'h9F]:        c = 4'd9;
      [8'hA0:8'hBF]:        c = 4'd7;
      8'hC0, 8'hC1:         c = 4'd8;
      [8'hC2:8'hDF]:        c = 4'd2;
      8'hE0:                c = 4'd10;
      [8'hE1:8'hEC]:        c = 4'd3;
      8'hED:                c = 4'd4;
      8'hEE, 8'hEF:         c = 4'd3;
      8'hF0:                c = 4'd11;
      [8'hF1:8'hF3]:        c = 4'd6;
      8'hF4:                c = 4'd5;
      default:              c = 4'd8;
    endcase
    return c;
  endfunction

  function automatic dfa_state_t next_state(input dfa_state_t s, input byte_class_t c);
    dfa_state_t n;
    n = ST_REJECT;
    case (s)
      4'd0: begin
        case (c)
          4'd0:    n = 4'd0;
          4'd2:    n = 4'd2;
          4'd3:    n = 4'd3;
          4'd4:    n = 4'd5;
          4'd5:    n = 4'd8;
          4'd6:    n = 4'd7;
          4'd10:   n = 4'd4;
          4'd11:   n = 4'd6;
          default: n = ST_REJECT;
        endcase
      end
      4'd2: begin
        if (c inside {4'd1, 4'd7, 4'd9}) n = 4'd0;
      end
      4'd3: begin
        if (c inside {4'd1, 4'd7, 4'd9}) n = 4'd2;
      end
      4'd4: begin
        if (c == 4'd7) n = 4'd2;
      end
      4'd5: begin
        if (c inside {4'd1, 4'd9}) n = 4'd2;
      end
      4'd6: begin
        if (c inside {4'd7, 4'd9}) n = 4'd3;
      end
      4'd7: begin
        if (c inside {4'd1, 4'd7, 4'd9}) n = 4'd3;
      end
      4'd8: begin
        if (c == 4'd1) n = 4'd3;
      end
      default: n = ST_REJECT;
    endcase
    return n;
  endfunction

endpackage

/* rtl/utf8v_step.sv */
// ----------------------------------------------------------------------------
// utf8v_step - one automaton step
// Classifies the byte, moves the automaton and shifts the byte's payload
// bits into the partial code point.
// ----------------------------------------------------------------------------
module utf8v_step (
  input  utf8v_pkg::dfa_state_t              state_i,
  input  logic [utf8v_pkg::CP_W-1:0]         value_i,
  input  logic                               err_i,
  input  logic [utf8v_pkg::BYTE_W-1:0]       byte_i,
  output utf8v_pkg::step_t                   step_o
);

  utf8v_pkg::byte_class_t   cls;
  utf8v_pkg::dfa_state_t    nstate;
  logic [utf8v_pkg::BYTE_W-1:0] lead_bits;
  logic [utf8v_pkg::CP_W-1:0]   value_nxt;

  assign cls       = utf8v_pkg::byte_class(byte_i);
  assign nstate    = utf8v_pkg::next_state(state_i, cls);
  // lead byte keeps only the bits below its length marker
  assign lead_bits = (8'hFF >> cls) & byte_i;

  always_comb begin
    if (state_i == utf8v_pkg::ST_ACCEPT) begin
      value_nxt = {{(utf8v_pkg::CP_W-utf8v_pkg::BYTE_W){1'b0}}, lead_bits};
    end else begin
      value_nxt = {value_i[utf8v_pkg::CP_W-7:0], byte_i[5:0]};
    end
  end

  // once an error is latched the automaton is frozen
  always_comb begin
    if (err_i) begin
      step_o.state   = state_i;
      step_o.value   = value_i;
      step_o.cp_done = 1'b0;
      step_o.reject  = 1'b0;
    end else begin
      step_o.state   = nstate;
      step_o.value   = value_nxt;
      step_o.cp_done = (nstate == utf8v_pkg::ST_ACCEPT);
      step_o.reject  = (nstate == utf8v_pkg::ST_REJECT);
    end
  end

endmodule

/* rtl/utf8v_count.sv */
// ----------------------------------------------------------------------------
// utf8v_count - saturating code point counter
// Counts completed code points per string; cleared after the last beat.
// ----------------------------------------------------------------------------
module utf8v_count #(
  parameter int unsigned COUNT_WIDTH = utf8v_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en_i,
  input  logic                               inc_i,
  input  logic                               clr_i,
  output logic [utf8v_pkg::CNT_OUT_W-1:0]    count_o
);

  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [COUNT_WIDTH-1:0] count_upd;

  // value including this beat, held at all ones
  assign count_upd = (inc_i && !(&count_r)) ? count_r + 1'b1 : count_r;

  always_comb begin
    count_nxt = count_r;
    if (en_i) begin
      count_nxt = clr_i ? '0 : count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  generate
    if (COUNT_WIDTH >= utf8v_pkg::CNT_OUT_W) begin : g_trunc
      assign count_o = count_upd[utf8v_pkg::CNT_OUT_W-1:0];
    end else begin : g_ext
      assign count_o = {{(utf8v_pkg::CNT_OUT_W-COUNT_WIDTH){1'b0}}, count_upd};
    end
  endgenerate

endmodule

/* rtl/utf8_validating_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_validating_decoder_core - streaming UTF-8 validating decoder
// Decodes one byte per beat and reports code points, count and status.
// ----------------------------------------------------------------------------
// Takes one byte per clock and gives one result beat per byte, registered
// in the cycle after it is taken. The automaton step is combinational logic
// between the state registers and the result register, so the throughput
// is one byte per cycle whenever the result side keeps up; a stalled result
// is held in the output register and the input waits only while that
// register is full and not being taken. in_tlast marks the final byte of a
// string: a string that ends inside a sequence reports status 2 on that
// beat, and all decoder state including the code point count is cleared
// afterwards. Invalid encodings latch status 2 until the end of the string.
// The count saturates at 2^COUNT_WIDTH-1 and is reported in 32 bits.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_core #(
  parameter int unsigned COUNT_WIDTH = utf8v_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [20:0] code_point, [52:21] code_point_count, zero pad
  output logic [2:0]  out_tuser,  // [0] code_point_ready, [2:1] status
  output logic        out_tlast   // end_of_string
);

  utf8v_pkg::dfa_state_t                 state_r, state_nxt;
  logic [utf8v_pkg::CP_W-1:0]            value_r, value_nxt;
  logic                                  err_r, err_nxt;
  utf8v_pkg::step_t                      step;
  logic [utf8v_pkg::CNT_OUT_W-1:0]       count;
  utf8v_pkg::status_t                    status;
  logic                                  in_acc;

  logic                                  out_valid_r, out_valid_nxt;
  logic                                  out_rdy_r;
  logic [utf8v_pkg::CP_W-1:0]            out_cp_r;
  logic [utf8v_pkg::CNT_OUT_W-1:0]       out_cnt_r;
  utf8v_pkg::status_t                    out_status_r;
  logic                                  out_last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  utf8v_step u_step (
    .state_i (state_r),
    .value_i (value_r),
    .err_i   (err_r),
    .byte_i  (in_tdata),
    .step_o  (step)
  );

  utf8v_count #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (in_acc),
    .inc_i   (step.cp_done),
    .clr_i   (in_tlast),
    .count_o (count)
  );

  always_comb begin
    if (err_r || step.reject) begin
      status = utf8v_pkg::STATUS_INVALID;
    end else if (step.state != utf8v_pkg::ST_ACCEPT) begin
      status = in_tlast ? utf8v_pkg::STATUS_INVALID : utf8v_pkg::STATUS_INSIDE;
    end else begin
      status = utf8v_pkg::STATUS_ACCEPT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    err_nxt   = err_r;
    if (in_acc) begin
      if (in_tlast) begin
        state_nxt = utf8v_pkg::ST_ACCEPT;
        value_nxt = '0;
        err_nxt   = 1'b0;
      end else begin
        state_nxt = step.state;
        value_nxt = step.value;
        err_nxt   = err_r || step.reject;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8v_pkg::ST_ACCEPT;
      value_r <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      value_r <= value_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on each accepted beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_rdy_r    <= step.cp_done;
      out_cp_r     <= step.cp_done ? step.value : '0;
      out_cnt_r    <= count;
      out_status_r <= status;
      out_last_r   <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_cp_r};
  assign out_tuser  = {out_status_r, out_rdy_r};
  assign out_tlast  = out_last_r;

  // a reported code point is always a valid scalar value
  a_cp_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[20:0] <= 21'h10FFFF &&
       (out_tdata[20:0] < 21'h00D800 || out_tdata[20:0] > 21'h00DFFF)))
    else $error("reported code point is not a scalar value");

  // a completed code point only ever comes with accept status
  a_cp_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == utf8v_pkg::STATUS_ACCEPT))
    else $error("code point reported with non-accept status");

  // decoder state is back to reset after the last byte of a string
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == utf8v_pkg::ST_ACCEPT && !err_r && value_r == '0))
    else $error("decoder state not cleared after end of string");

  // a latched error reports invalid on the next beat
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && err_r) |=> (out_tuser[2:1] == utf8v_pkg::STATUS_INVALID && !out_tuser[0]))
    else $error("latched error not reported");

endmodule
